>>> design/orb_pkg.sv
package orb_pkg;

  // fixed port widths
  localparam int CapW   = 5;
  localparam int ActW   = 2;
  localparam int CountW = 8;
  localparam int DataW  = 64;

  // defaults for the top level parameters
  localparam int DefDepth    = 16;
  localparam int DefWordBits = 64;

  // capacity after reset
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  // action codes
  localparam logic [ActW-1:0] ActAppend = 2'd0;
  localparam logic [ActW-1:0] ActRemove = 2'd1;
  localparam logic [ActW-1:0] ActList   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic cfg_wr;     // load capacity, empty the ring
    logic append;     // store payload after newest entry
    logic remove;     // drop oldest entries
    logic list_load;  // start a list walk at the oldest entry
    logic issue;      // read one entry into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;      // occupancy is zero
    logic last;       // walk has one entry left
  } status_t;

endpackage

>>> design/orb_ctrl.sv
module orb_ctrl
  import orb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [ActW-1:0] action_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  status_t         status_i,
  output cmd_t            cmd_o
);

  typedef enum logic {
    StIdle,
    StList
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  always_comb begin
    cfg_ready_o = (state_q == StIdle);
    in_ready_o  = (state_q == StIdle) && !cfg_valid_i;
    in_acc      = in_valid_i && in_ready_o;

    cmd_o        = '0;
    cmd_o.cfg_wr = cfg_valid_i && cfg_ready_o;
    state_d      = state_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (action_i)
            ActAppend: cmd_o.append = 1'b1;
            ActRemove: cmd_o.remove = 1'b1;
            ActList: begin
              if (!status_i.empty) begin
                cmd_o.list_load = 1'b1;
                state_d         = StList;
              end
            end
            default: ;
          endcase
        end
      end
      StList: begin
        cmd_o.issue = !out_valid_q || out_ready_i;
        if (cmd_o.issue && status_i.last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (cmd_o.issue) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/orb_dp.sv
module orb_dp
  import orb_pkg::*;
#(
  parameter int DEPTH     = DefDepth,
  parameter int WORD_BITS = DefWordBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [CapW-1:0]   cfg_capacity_i,
  input  logic [DataW-1:0]  payload_i,
  input  logic [CountW-1:0] remove_count_i,
  output logic [DataW-1:0]  entry_o,
  output logic              is_last_o,
  output status_t           status_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OccW = $clog2(DEPTH + 1);
  localparam int SumW = IdxW + 1;

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rd_q;
  logic                 last_q;

  logic [CapW-1:0] capacity_q;
  logic [IdxW-1:0] oldest_q, oldest_d;
  logic [IdxW-1:0] newest_q, newest_d;
  logic [OccW-1:0] occ_q, occ_d;
  logic [IdxW-1:0] walk_q, walk_d;
  logic [OccW-1:0] left_q, left_d;

  logic [OccW-1:0] size;
  logic [SumW-1:0] size_w;
  logic [IdxW-1:0] oldest_adv, newest_adv, walk_adv, wr_idx;
  logic [SumW-1:0] drop_sum;
  logic            full;

  // ring size clamped to 1..DEPTH
  always_comb begin
    if (capacity_q == '0) begin
      size = OccW'(1);
    end else if (int'(capacity_q) > DEPTH) begin
      size = OccW'(DEPTH);
    end else begin
      size = OccW'(capacity_q);
    end
    size_w = SumW'(size);
  end

  function automatic logic [IdxW-1:0] adv(input logic [IdxW-1:0] idx,
                                          input logic [SumW-1:0] sz);
    logic [SumW-1:0] nxt;
    nxt = SumW'(idx) + SumW'(1);
    return (nxt >= sz) ? '0 : nxt[IdxW-1:0];
  endfunction

  always_comb begin
    oldest_adv = adv(oldest_q, size_w);
    newest_adv = adv(newest_q, size_w);
    walk_adv   = adv(walk_q, size_w);
    full       = (occ_q >= size);
    wr_idx     = (occ_q == '0) ? '0 : newest_adv;
    // count stays below occupancy here, so the sum stays below twice the size
    drop_sum   = SumW'(oldest_q) + SumW'(remove_count_i[OccW-1:0]);
    if (drop_sum >= size_w) begin
      drop_sum = drop_sum - size_w;
    end

    oldest_d = oldest_q;
    newest_d = newest_q;
    occ_d    = occ_q;
    walk_d   = walk_q;
    left_d   = left_q;

    if (cmd_i.cfg_wr) begin
      oldest_d = '0;
      newest_d = '0;
      occ_d    = '0;
    end else if (cmd_i.append) begin
      if (occ_q == '0) begin
        oldest_d = '0;
        newest_d = '0;
        occ_d    = OccW'(1);
      end else begin
        if (full) begin
          oldest_d = oldest_adv;
        end else begin
          occ_d = occ_q + OccW'(1);
        end
        newest_d = newest_adv;
      end
    end else if (cmd_i.remove) begin
      if (occ_q != '0 && remove_count_i != '0) begin
        if (remove_count_i >= CountW'(occ_q)) begin
          oldest_d = '0;
          newest_d = '0;
          occ_d    = '0;
        end else begin
          oldest_d = drop_sum[IdxW-1:0];
          occ_d    = occ_q - remove_count_i[OccW-1:0];
        end
      end
    end

    if (cmd_i.list_load) begin
      walk_d = oldest_q;
      left_d = occ_q;
    end else if (cmd_i.issue) begin
      walk_d = walk_adv;
      left_d = left_q - OccW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
      oldest_q   <= '0;
      newest_q   <= '0;
      occ_q      <= '0;
      walk_q     <= '0;
      left_q     <= '0;
    end else begin
      if (cmd_i.cfg_wr) begin
        capacity_q <= cfg_capacity_i;
      end
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      occ_q    <= occ_d;
      walk_q   <= walk_d;
      left_q   <= left_d;
    end
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem_q[wr_idx] <= payload_i[WORD_BITS-1:0];
    end
    if (cmd_i.issue) begin
      rd_q   <= mem_q[walk_q];
      last_q <= (left_q == OccW'(1));
    end
  end

  assign entry_o         = DataW'(rd_q);
  assign is_last_o       = last_q;
  assign status_o.empty  = (occ_q == '0);
  assign status_o.last   = (left_q == OccW'(1));

endmodule

>>> design/overwriting_ring_buffer.sv
// append and remove: the next item can follow in the next cycle unless a capacity write waits
// list of n entries: the walk starts at the oldest entry and reads each into the output
//   register, one entry per cycle while the output is taken; input is held off for the walk
// the single read port of the slot memory sets the one-entry-per-cycle list rate
// reset: ring empty, both indices at slot 0, capacity 16; slot memory not cleared
module overwriting_ring_buffer
  import orb_pkg::*;
#(
  parameter int DEPTH     = DefDepth,
  parameter int WORD_BITS = DefWordBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  // command items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ActW-1:0]   action_i,
  input  logic [DataW-1:0]  payload_i,
  input  logic [CountW-1:0] remove_count_i,

  // capacity register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CapW-1:0]   cfg_capacity_i,

  // listed entries
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DataW-1:0]  entry_o,
  output logic              is_last_o
);

  cmd_t    cmd;
  status_t status;

  // controller: idle / list walk, output valid flag
  orb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: ring pointers, occupancy, slot memory and output register
  orb_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_capacity_i (cfg_capacity_i),
    .payload_i      (payload_i),
    .remove_count_i (remove_count_i),
    .entry_o        (entry_o),
    .is_last_o      (is_last_o),
    .status_o       (status)
  );

  // a list of a non-empty ring blocks the input for the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ActList && !status.empty |=> !in_ready_o)
    else $error("list item did not start a walk");

  // an append always leaves at least one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ActAppend |=> !status.empty)
    else $error("ring empty after append");

  // a capacity write empties the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> status.empty)
    else $error("ring not empty after capacity write");

  // the walk ends on the entry marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue && status.last |=> in_ready_o || cfg_valid_i)
    else $error("walk did not end after last entry");

endmodule
